/* rtl/aosc_pkg.sv */
// Shared types, widths and helpers for the accelerator oscillator.
// No dependencies; imported by every module of the block.
`default_nettype none
package aosc_pkg;

  localparam int PRICE_W    = 32;
  localparam int MED_W      = 33;   // high + low
  localparam int TOT_W      = 39;   // window sum of medians
  localparam int SIG_TOT_W  = 40;   // signed sum of oscillators
  localparam int OSC_W      = 34;
  localparam int AC_W       = 35;
  localparam int PER_W      = 7;
  localparam int SPER_W     = 6;
  localparam int BARS_W     = 8;
  localparam int MAX_WINDOW = 64;
  localparam int MAX_SIGNAL = 32;
  localparam int MSLOT_W    = $clog2(MAX_WINDOW);
  localparam int OSLOT_W    = $clog2(MAX_SIGNAL);
  localparam int CFG_IDX_W  = 2;

  // shared divider: 2 quotient bits per cycle
  localparam int DIV_NUM_W  = 42;
  localparam int DIV_DEN_W  = 7;
  localparam int DIV_STEPS  = DIV_NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_RDS, OP_DIVF, OP_CAPF,
    OP_DIVS, OP_CAPS, OP_OSC, OP_DIVG, OP_CAPG, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RDS, S_DIVF, S_WF, S_DIVS, S_WS,
    S_OSC, S_DIVG, S_WG, S_OUT
  } state_e;

  typedef struct packed {
    logic div_done;
    logic pre_osc;   // bar still ahead of the first oscillator
    logic emit;      // warm-up over, this bar gives a result
    logic out_free;  // output register can take a value
  } status_t;

  function automatic logic [PER_W-1:0] clamp_win(input logic [PER_W-1:0] p);
    logic [PER_W-1:0] r;
    if (p < PER_W'(2)) r = PER_W'(2);
    else if (p > PER_W'(MAX_WINDOW)) r = PER_W'(MAX_WINDOW);
    else r = p;
    return r;
  endfunction

  function automatic logic [SPER_W-1:0] clamp_sig(input logic [SPER_W-1:0] p);
    logic [SPER_W-1:0] r;
    if (p < SPER_W'(2)) r = SPER_W'(2);
    else if (p > SPER_W'(MAX_SIGNAL)) r = SPER_W'(MAX_SIGNAL);
    else r = p;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/aosc_div.sv */
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on aosc_pkg.
`default_nettype none
module aosc_div import aosc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W:0]   r1, r2;
  logic [DIV_DEN_W-1:0] r1s;
  logic                 ge1, ge2;

  always_comb begin
    r1    = {rem_q, num_q[DIV_NUM_W-1]};
    ge1   = r1 >= {1'b0, den_q};
    r1s   = ge1 ? DIV_DEN_W'(r1 - {1'b0, den_q}) : r1[DIV_DEN_W-1:0];
    r2    = {r1s, num_q[DIV_NUM_W-2]};
    ge2   = r2 >= {1'b0, den_q};
    rem_d = ge2 ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
    num_d = {num_q[DIV_NUM_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

/* rtl/aosc_ctrl.sv */
// Sequencer for one bar: issues datapath ops, waits on the divider.
// Depends on aosc_pkg.
`default_nettype none
module aosc_ctrl import aosc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output op_e          op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: state_d = S_RDS;
      S_RDS:  state_d = S_DIVF;
      S_DIVF: state_d = S_WF;
      S_WF:   if (status_i.div_done) state_d = S_DIVS;
      S_DIVS: state_d = S_WS;
      S_WS:   if (status_i.div_done) state_d = status_i.pre_osc ? S_IDLE : S_OSC;
      S_OSC:  state_d = S_DIVG;
      S_DIVG: state_d = S_WG;
      S_WG:   if (status_i.div_done) state_d = status_i.emit ? S_OUT : S_IDLE;
      S_OUT:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: if (in_valid_i) op_o = OP_LOAD;
      S_PREP: op_o = OP_PREP;
      S_RDS:  op_o = OP_RDS;
      S_DIVF: op_o = OP_DIVF;
      S_WF:   if (status_i.div_done) op_o = OP_CAPF;
      S_DIVS: op_o = OP_DIVS;
      S_WS:   if (status_i.div_done) op_o = OP_CAPS;
      S_OSC:  op_o = OP_OSC;
      S_DIVG: op_o = OP_DIVG;
      S_WG:   if (status_i.div_done) op_o = OP_CAPG;
      S_OUT:  if (status_i.out_free) op_o = OP_OUT;
      default: op_o = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/aosc_dp.sv */
// Datapath: config registers, median and oscillator rings, running sums,
// shared divider and output register. Depends on aosc_pkg, aosc_div.
`default_nettype none
module aosc_dp import aosc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire op_e                  op_i,
  output status_t                   status_o,
  input  wire logic [PRICE_W-1:0]   high_price_i,
  input  wire logic [PRICE_W-1:0]   low_price_i,
  input  wire logic                 start_of_series_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [PER_W-1:0]     cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [AC_W-1:0]    ac_value_o
);

  logic [PER_W-1:0]  fast_q, slow_q;
  logic [SPER_W-1:0] sig_q;
  logic [PER_W-1:0]  fp, sp, longest, osc_start;
  logic [SPER_W-1:0] gp;
  logic [BARS_W-1:0] warm;

  logic [TOT_W-1:0]     ft_q, st_q;
  logic [SIG_TOT_W-1:0] gt_q;
  logic [BARS_W-1:0]    bars_q;
  logic [MSLOT_W-1:0]   ms_q;
  logic [OSLOT_W-1:0]   os_q, os_next;

  logic [MED_W-1:0] med_q, fold_q, sold_q, med_rd_q;
  logic [MED_W-1:0] qf_q;
  logic [OSC_W-1:0] osc_q, oold_q, osc_rd_q;
  logic [AC_W-1:0]  ac_q, out_q;
  logic             gneg_q;
  logic             out_valid_q;

  logic [MED_W-1:0] med_mem [MAX_WINDOW];
  logic [OSC_W-1:0] osc_mem [MAX_SIGNAL];
  logic [MSLOT_W-1:0] med_raddr;

  logic cfg_hit, clr, fast_sub, slow_sub, pre_osc, emit, out_free;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot, g_ext, gmag;
  logic [DIV_DEN_W-1:0] div_den;
  logic [SIG_TOT_W-1:0] mean;

  // effective periods and warm-up thresholds
  always_comb begin
    fp        = clamp_win(fast_q);
    sp        = clamp_win(slow_q);
    gp        = clamp_sig(sig_q);
    longest   = (fp > sp) ? fp : sp;
    osc_start = longest - 1'b1;
    warm      = BARS_W'({1'b0, osc_start} + BARS_W'(gp) - 1'b1);
    pre_osc   = bars_q < BARS_W'(osc_start);
    emit      = bars_q >= warm;
    fast_sub  = bars_q >= BARS_W'(fp - 1'b1);
    slow_sub  = bars_q >= BARS_W'(sp - 1'b1);
    os_next   = (SPER_W'(os_q) + 1'b1 == gp) ? '0 : os_q + 1'b1;
  end

  assign cfg_hit = cfg_valid_i && (cfg_index_i == CFG_FAST || cfg_index_i == CFG_SLOW ||
                                   cfg_index_i == CFG_SIGNAL);
  assign clr     = cfg_hit || (op_i == OP_LOAD && start_of_series_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= PER_W'(5);
      slow_q <= PER_W'(34);
      sig_q  <= SPER_W'(5);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAST:   fast_q <= cfg_data_i;
        CFG_SLOW:   slow_q <= cfg_data_i;
        CFG_SIGNAL: sig_q  <= cfg_data_i[SPER_W-1:0];
        default: ;
      endcase
    end
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= '0; st_q <= '0; gt_q <= '0;
      bars_q <= '0; ms_q <= '0; os_q <= '0;
    end else if (clr) begin
      ft_q <= '0; st_q <= '0; gt_q <= '0;
      bars_q <= '0; ms_q <= '0; os_q <= '0;
    end else begin
      unique case (op_i)
        OP_PREP: begin
          ft_q <= ft_q + TOT_W'(med_q);
          st_q <= st_q + TOT_W'(med_q);
        end
        OP_CAPS: begin
          if (fast_sub) ft_q <= ft_q - TOT_W'(fold_q);
          if (slow_sub) st_q <= st_q - TOT_W'(sold_q);
          ms_q <= ms_q + 1'b1;
          if (pre_osc) bars_q <= bars_q + 1'b1;
        end
        OP_OSC: gt_q <= gt_q + {{(SIG_TOT_W-OSC_W){osc_q[OSC_W-1]}}, osc_q};
        OP_CAPG: begin
          os_q <= os_next;
          if (emit) gt_q <= gt_q - {{(SIG_TOT_W-OSC_W){oold_q[OSC_W-1]}}, oold_q};
          else      bars_q <= bars_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // rings: one write and one registered read each
  assign med_raddr = (op_i == OP_RDS) ? ms_q - MSLOT_W'(sp - 1'b1)
                                      : ms_q - MSLOT_W'(fp - 1'b1);

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PREP) med_mem[ms_q] <= med_q;
    med_rd_q <= med_mem[med_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_OSC) osc_mem[os_q] <= osc_q;
    osc_rd_q <= osc_mem[os_next];
  end

  // divider operand select; floor of a negative sum via ceil of its magnitude
  always_comb begin
    g_ext = {{(DIV_NUM_W-SIG_TOT_W){gt_q[SIG_TOT_W-1]}}, gt_q};
    gmag  = gt_q[SIG_TOT_W-1] ? (DIV_NUM_W'(0) - g_ext + DIV_NUM_W'(gp) - 1'b1) : g_ext;
    div_start = 1'b0;
    div_num   = gmag;
    div_den   = DIV_DEN_W'(gp);
    unique case (op_i)
      OP_DIVF: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(ft_q[TOT_W-1:1]);
        div_den   = fp;
      end
      OP_DIVS: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(st_q[TOT_W-1:1]);
        div_den   = sp;
      end
      OP_DIVG: div_start = 1'b1;
      default: ;
    endcase
    mean = gneg_q ? SIG_TOT_W'(0) - div_quot[SIG_TOT_W-1:0] : div_quot[SIG_TOT_W-1:0];
  end

  aosc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: med_q  <= {1'b0, high_price_i} + {1'b0, low_price_i};
      OP_RDS:  fold_q <= med_rd_q;
      OP_DIVF: sold_q <= med_rd_q;
      OP_CAPF: qf_q   <= div_quot[MED_W-1:0];
      OP_CAPS: osc_q  <= {1'b0, qf_q} - {1'b0, div_quot[MED_W-1:0]};
      OP_DIVG: begin
        oold_q <= osc_rd_q;
        gneg_q <= gt_q[SIG_TOT_W-1];
      end
      OP_CAPG: ac_q <= AC_W'({{(SIG_TOT_W-OSC_W){osc_q[OSC_W-1]}}, osc_q} - mean);
      OP_OUT:  out_q <= ac_q;
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              out_valid_q <= 1'b0;
    else if (op_i == OP_OUT)  out_valid_q <= 1'b1;
    else if (!out_stall_i)    out_valid_q <= 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign ac_value_o  = out_q;

  assign status_o = '{div_done: div_done, pre_osc: pre_osc, emit: emit, out_free: out_free};

`ifndef NO_ASSERTIONS
  a_cap_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_CAPF || op_i == OP_CAPS || op_i == OP_CAPG) |-> div_done)
    else $error("quotient captured before divider finished");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(op_i == OP_OUT))
    else $error("output valid without an output load");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SPER_W'(os_q) < gp)
    else $error("oscillator slot outside signal window");
`endif

endmodule
`default_nettype wire

/* rtl/accelerator_oscillator_top.sv */
// Accelerator oscillator: one result per price bar once warm-up is over.
// One bar at a time: the input is stalled until the sequencer is idle again.
// Fast and slow divides for every bar, plus a signal-mean divide once oscillators start.
// Bar rate is set by these passes through the shared 2-bit/cycle divider.
// Reset (rst_ni low, async): periods 5/34/5, sums, slots and warm-up count zero.
// Depends on aosc_pkg, aosc_ctrl, aosc_dp, aosc_div.
`default_nettype none
module accelerator_oscillator_top import aosc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // bar input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PRICE_W-1:0]   high_price_i,
  input  wire logic [PRICE_W-1:0]   low_price_i,
  input  wire logic                 start_of_series_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [AC_W-1:0]    ac_value_o,
  // configuration writes, always ready; any valid register write restarts
  // the series
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [PER_W-1:0]     cfg_data_i
);

  op_e     op;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer: one bar at a time, input stalled while it is in flight
  aosc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  // rings, sums, divider and the output register that decouples the
  // result side from the next bar
  aosc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .status_o          (status),
    .high_price_i      (high_price_i),
    .low_price_i       (low_price_i),
    .start_of_series_i (start_of_series_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ac_value_o        (ac_value_o)
  );

endmodule
`default_nettype wire

/* bench/accelerator_oscillator_top_tb.sv */
// Self-checking bench for accelerator_oscillator_top: bar stream in, AC values out.
// Depends on aosc_pkg and the RTL of the block; predicts results internally.
`timescale 1ns / 1ps
module accelerator_oscillator_top_tb;
  import aosc_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int DRAIN_WAIT = 120;      // longer than one bar's processing, covers silent bars
  localparam int CYCLE_CAP  = 4000000;
  localparam int BARS_PER_PHASE = 150;  // well past the longest warm-up (94)
  localparam int NUM_PHASES = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // not a register

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PRICE_W-1:0] high_price_i = '0;
  logic [PRICE_W-1:0] low_price_i = '0;
  logic start_of_series_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [AC_W-1:0] ac_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [PER_W-1:0] cfg_data_i = '0;

  accelerator_oscillator_top dut (.*);

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: period registers plus the running series.
  // ---------------------------------------------------------------------------
  logic [PER_W-1:0]  fast_reg = 7'd5;
  logic [PER_W-1:0]  slow_reg = 7'd34;
  logic [SPER_W-1:0] sig_reg  = 6'd5;
  longint unsigned median_ring [MAX_WINDOW];
  longint          osc_ring [MAX_SIGNAL];
  longint unsigned fast_sum, slow_sum;
  longint          osc_sum;
  int              bar_count, med_pos, osc_pos;

  logic [AC_W-1:0] ac_expected_q [$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet  = 1'b0;   // set for a stretch with no idling on either side

  function automatic void restart_series();
    fast_sum = 0;
    slow_sum = 0;
    osc_sum = 0;
    bar_count = 0;
    med_pos = 0;
    osc_pos = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [PER_W-1:0] data);
    case (idx)
      CFG_FAST:   fast_reg = data;
      CFG_SLOW:   slow_reg = data;
      CFG_SIGNAL: sig_reg = data[SPER_W-1:0];
      default: return;      // unknown index: no effect, series kept
    endcase
    restart_series();
  endfunction

  function automatic int clip(int p, int hi);
    return (p < 2) ? 2 : ((p > hi) ? hi : p);
  endfunction

  // Advance the series by one bar; returns 1 when the bar yields an AC value.
  function automatic bit predict_ac(logic [31:0] hi, logic [31:0] lo, logic sos,
                                    output logic [AC_W-1:0] ac);
    int fp, sp, gp, longest, warm;
    longint unsigned med;
    longint osc, mean;
    fp = clip(int'(fast_reg), MAX_WINDOW);
    sp = clip(int'(slow_reg), MAX_WINDOW);
    gp = clip(int'(sig_reg), MAX_SIGNAL);
    longest = (fp > sp) ? fp : sp;
    warm = longest - 1 + gp - 1;
    ac = '0;
    if (sos) restart_series();

    med = longint'(hi) + longint'(lo);
    median_ring[med_pos] = med;
    fast_sum += med;
    slow_sum += med;
    osc = longint'(fast_sum / (2 * fp)) - longint'(slow_sum / (2 * sp));
    if (bar_count >= fp - 1)
      fast_sum -= median_ring[(med_pos + MAX_WINDOW - (fp - 1)) % MAX_WINDOW];
    if (bar_count >= sp - 1)
      slow_sum -= median_ring[(med_pos + MAX_WINDOW - (sp - 1)) % MAX_WINDOW];
    med_pos = (med_pos + 1) % MAX_WINDOW;

    if (bar_count < longest - 1) begin
      bar_count++;
      return 1'b0;
    end
    osc_pos = osc_pos % gp;
    osc_ring[osc_pos] = osc;
    osc_sum += osc;
    mean = osc_sum / gp;                       // truncates; fix toward -inf
    if ((osc_sum % gp) != 0 && osc_sum < 0) mean--;
    ac = AC_W'(osc - mean);
    osc_pos = (osc_pos + 1) % gp;
    if (bar_count < warm) begin
      bar_count++;
      return 1'b0;
    end
    osc_sum -= osc_ring[osc_pos];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge.
  // ---------------------------------------------------------------------------
  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < 33);
  endfunction

  // fixed_zero: value is known to be zero (fast and slow windows equal)
  task automatic send_bar(logic [31:0] hi, logic [31:0] lo, logic sos, bit fixed_zero);
    logic [AC_W-1:0] ac;
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    high_price_i <= hi;
    low_price_i <= lo;
    start_of_series_i <= sos;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_ac(hi, lo, sos, ac)) ac_expected_q.push_back(fixed_zero ? '0 : ac);
    @(negedge clk_i);
  endtask

  // Registers change only with the block idle: queue drained, then a bar time.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (ac_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One write, then cfg_valid_i dropped low so back-to-back writes never collide.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PER_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result side stall, random except in the quiet stretch.
  always @(negedge clk_i) out_stall_i <= idle_roll();

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ac_expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d", $time, ac_value_o);
        errors++;
      end else begin
        if (ac_value_o !== ac_expected_q[0]) begin
          $display("%0t ac_value mismatch: expected %0d, actual %0d", $time,
                   $signed(ac_expected_q[0]), ac_value_o);
          errors++;
        end
        void'(ac_expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: register writes and bars with extreme prices.
  // ---------------------------------------------------------------------------
  typedef enum bit {ROW_CFG, ROW_BAR} row_kind_e;
  typedef struct {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [PER_W-1:0] data;
    logic [31:0] hi;
    logic [31:0] lo;
    logic sos;
    bit zero;   // AC known to be zero
  } row_t;

  row_t dir_rows [] = '{
    // unknown index first: must not touch the defaults
    '{ROW_CFG, CFG_UNUSED, 7'd7, 0, 0, 0, 0},
    // periods below 2 clamp to 2: fast = slow, so every AC is zero
    '{ROW_CFG, CFG_FAST,   7'd0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SLOW,   7'd1, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SIGNAL, 7'd0, 0, 0, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 1, 1},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1},
    '{ROW_BAR, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1},
    '{ROW_BAR, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1},
    '{ROW_BAR, 0, 0, 32'h0000_0001, 32'h0000_0000, 0, 1},
    // periods above the maximum clamp to 64 / 64 / 32
    '{ROW_CFG, CFG_FAST,   7'd127, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SLOW,   7'd100, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SIGNAL, 7'd63,  0, 0, 0, 0},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0},
    // short, unequal windows: swings between extremes give large AC
    '{ROW_CFG, CFG_FAST,   7'd2, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SLOW,   7'd3, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SIGNAL, 7'd66, 0, 0, 0, 0},   // bit 6 dropped: signal 2
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
    '{ROW_BAR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'h0000_0000, 1, 0},
    '{ROW_BAR, 0, 0, 32'h1234_5678, 32'h8765_4321, 0, 0},
    '{ROW_BAR, 0, 0, 32'hFFFF_0000, 32'h0000_FFFF, 0, 0},
    '{ROW_BAR, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0}
  };

  // Per-phase periods: extremes first, then random register values.
  logic [PER_W-1:0] phase_fast [NUM_PHASES] = '{2, 64, 127, 5, 64, 2, 0, 0, 0, 0, 0, 0};
  logic [PER_W-1:0] phase_slow [NUM_PHASES] = '{2, 64, 0, 34, 2, 64, 0, 0, 0, 0, 0, 0};
  logic [PER_W-1:0] phase_sig  [NUM_PHASES] = '{2, 32, 63, 5, 32, 2, 0, 0, 0, 0, 0, 0};

  logic [31:0] level;   // center of the trending price walk

  function automatic logic [31:0] pick_price();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return level + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] hi, lo;
    restart_series();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_bar(dir_rows[r].hi, dir_rows[r].lo, dir_rows[r].sos, dir_rows[r].zero);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if (ph >= 6) begin
        phase_fast[ph] = PER_W'($urandom_range(127));
        phase_slow[ph] = PER_W'($urandom_range(127));
        phase_sig[ph]  = PER_W'($urandom_range(127));
      end
      if ($urandom_range(1)) write_reg(CFG_UNUSED, PER_W'($urandom_range(127)));
      write_reg(CFG_SIGNAL, phase_sig[ph]);
      write_reg(CFG_FAST, phase_fast[ph]);
      write_reg(CFG_SLOW, phase_slow[ph]);
      quiet = (ph == 3);
      level = $urandom();
      for (int b = 0; b < BARS_PER_PHASE; b++) begin
        // hold off once per phase until every result is back
        if (b == BARS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          while (ac_expected_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        level += $urandom_range(32'h0002_0000) - 32'h0001_0000;
        hi = pick_price();
        lo = pick_price();
        send_bar(hi, lo, $urandom_range(59) == 0, 1'b0);
      end
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    while (ac_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
